/* rtl/pacp_pkg.sv */
package pacp_pkg;

    localparam int unsigned MaxVertices = 256;
    localparam int unsigned CoordBits   = 16;
    localparam int unsigned FracBits    = 8;
    localparam int unsigned CountBits   = 13;
    localparam int unsigned RootSteps   = 32 + FracBits;
    localparam int unsigned RootStepBits = 6;
    localparam int unsigned DivSteps    = 64;
    localparam int unsigned DivStepBits = 7;

    localparam logic [1:0] StatusOk         = 2'd0;
    localparam logic [1:0] StatusDegenerate = 2'd1;
    localparam logic [1:0] StatusOverflow   = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_A,
        ST_MUL_B,
        ST_MOMENT_X,
        ST_MOMENT_Y,
        ST_SQ_DX,
        ST_SQ_DY,
        ST_ROOT,
        ST_EDGE_DONE,
        ST_FINISH,
        ST_DIV_X,
        ST_DIV_Y,
        ST_OUTPUT
    } t_state;

endpackage

/* rtl/polygon_area_centroid_perimeter_unit.sv */
// Streams polygon vertices (x, y, last) and returns, after the last vertex,
// twice the absolute shoelace area, the perimeter with 8 fraction bits (each
// edge root truncated) and the centroid, truncated toward zero and saturated.
// Status 0 ok, 1 zero area (centroid 0), 2 more than 256 vertices (all else 0).
// One shared 17x33-bit multiplier, a one-bit-per-cycle square root and a
// one-bit-per-cycle divider do the work: a vertex that adds an edge keeps the
// input busy after its transfer for six products in turn, a 40-step square
// root and an update of the sums; the first vertex of a polygon, unless it is
// also the last, leaves the input ready. The last vertex adds its edge and the
// closing edge and, when the area is not zero, runs two 64-step divisions
// before the result register is loaded. The input is not ready while busy; the
// result waits in an output register and the next polygon can start meanwhile,
// but a result that finds that register still full holds the input off until
// it is free.
module polygon_area_centroid_perimeter_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // vertex_x[15:0], vertex_y[31:16]
    input  logic        s_axis_tlast,  // last_vertex
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [103:0] m_axis_tdata  // area_doubled[33:0], perimeter_fixed[66:34],
                                       // centroid_x[82:67], centroid_y[98:83],
                                       // status[100:99], zero fill above
);

    localparam int unsigned CB = pacp_pkg::CoordBits;

    pacp_pkg::t_state r_state, n_state;

    logic signed [CB-1:0] r_first_x, r_first_y, r_prev_x, r_prev_y, r_cur_x, r_cur_y;
    logic [47:0] r_cross_sum;
    logic [63:0] r_mom_x, r_mom_y;
    logic [35:0] r_len_sum;
    logic [pacp_pkg::CountBits-1:0] r_count;
    logic r_ovf, r_last, r_closing;
    logic signed [32:0] r_c;          // edge cross product
    logic [63:0] r_sq;                // dx^2 + dy^2 (partial, then full)
    logic [63:0] r_rem, r_root;
    logic [pacp_pkg::RootStepBits-1:0] r_rstep;
    logic [63:0] r_dnum, r_drem, r_dden;
    logic [pacp_pkg::DivStepBits-1:0] r_dstep;
    logic r_dneg;
    logic signed [CB-1:0] r_cx, r_cy;
    logic r_out_valid;
    logic [103:0] r_out, n_out;

    logic signed [CB-1:0] in_x, in_y;
    assign in_x = s_axis_tdata[CB-1:0];
    assign in_y = s_axis_tdata[16+CB-1:16];

    // edge endpoints: current edge goes previous -> b
    logic signed [CB-1:0] b_x, b_y;
    assign b_x = r_closing ? r_first_x : r_cur_x;
    assign b_y = r_closing ? r_first_y : r_cur_y;

    // shared multiplier operands
    logic signed [CB:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [CB+33:0] mul_p;
    logic signed [CB:0] dx, dy;
    assign dx = (CB+1)'(b_x) - (CB+1)'(r_prev_x);
    assign dy = (CB+1)'(b_y) - (CB+1)'(r_prev_y);
    always_comb begin
        case (r_state)
            pacp_pkg::ST_MUL_A: begin mul_a = (CB+1)'(r_prev_x); mul_b = 33'(b_y); end
            pacp_pkg::ST_MUL_B: begin mul_a = (CB+1)'(b_x);      mul_b = 33'(r_prev_y); end
            pacp_pkg::ST_MOMENT_X: begin
                mul_a = (CB+1)'(r_prev_x) + (CB+1)'(b_x); mul_b = r_c;
            end
            pacp_pkg::ST_MOMENT_Y: begin
                mul_a = (CB+1)'(r_prev_y) + (CB+1)'(b_y); mul_b = r_c;
            end
            pacp_pkg::ST_SQ_DY: begin mul_a = dy; mul_b = 33'(dy); end
            default: begin mul_a = dx; mul_b = 33'(dx); end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    // one root step
    logic [63:0] rt_pair, rt_rem, rt_trial, rt_root_sh;
    always_comb begin
        rt_pair = (r_rstep >= pacp_pkg::RootStepBits'(pacp_pkg::FracBits))
            ? ((r_sq >> (2 * (r_rstep - pacp_pkg::RootStepBits'(pacp_pkg::FracBits))))
               & 64'd3) : 64'd0;
        rt_rem = (r_rem << 2) | rt_pair;
        rt_root_sh = r_root << 1;
        rt_trial = (rt_root_sh << 1) | 64'd1;
    end

    // one restoring divide step on magnitudes
    logic [64:0] dv_rem;
    logic dv_ge;
    assign dv_rem = {r_drem, r_dnum[63]};
    assign dv_ge = dv_rem >= {1'b0, r_dden};

    // final values
    logic signed [63:0] cross_s;
    logic [63:0] area_abs;
    logic signed [63:0] den3;
    assign cross_s = (r_count < pacp_pkg::CountBits'(3)) ? 64'sd0 : 64'(signed'(r_cross_sum));
    assign area_abs = cross_s[63] ? 64'(-cross_s) : 64'(cross_s);
    assign den3 = cross_s * 64'sd3;

    logic signed [CB-1:0] q_sat;
    always_comb begin
        logic [63:0] q;
        q = {r_dnum[62:0], dv_ge};
        if (r_dneg) begin
            q_sat = (q > 64'(1 << (CB-1))) ? CB'(1 << (CB-1)) : CB'(-q);
        end else begin
            q_sat = (q > 64'((1 << (CB-1)) - 1)) ? CB'((1 << (CB-1)) - 1) : CB'(q);
        end
    end

    function automatic logic [63:0] abs64(input logic [63:0] v);
        abs64 = v[63] ? -v : v;
    endfunction

    logic do_edge_in, out_free;
    assign out_free = !r_out_valid || m_axis_tready;
    assign s_axis_tready = (r_state == pacp_pkg::ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata = r_out;
    assign do_edge_in = (r_count != '0) && (r_count < pacp_pkg::CountBits'(pacp_pkg::MaxVertices));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            pacp_pkg::ST_IDLE:
                if (s_axis_tvalid) begin
                    if (do_edge_in) n_state = pacp_pkg::ST_MUL_A;
                    else if (s_axis_tlast) n_state = pacp_pkg::ST_FINISH;
                end
            pacp_pkg::ST_MUL_A:    n_state = pacp_pkg::ST_MUL_B;
            pacp_pkg::ST_MUL_B:    n_state = pacp_pkg::ST_MOMENT_X;
            pacp_pkg::ST_MOMENT_X: n_state = pacp_pkg::ST_MOMENT_Y;
            pacp_pkg::ST_MOMENT_Y: n_state = pacp_pkg::ST_SQ_DX;
            pacp_pkg::ST_SQ_DX:    n_state = pacp_pkg::ST_SQ_DY;
            pacp_pkg::ST_SQ_DY:    n_state = pacp_pkg::ST_ROOT;
            pacp_pkg::ST_ROOT:
                if (r_rstep == '0) n_state = pacp_pkg::ST_EDGE_DONE;
            pacp_pkg::ST_EDGE_DONE:
                if (r_closing) n_state = pacp_pkg::ST_DIV_X;
                else if (r_last) n_state = pacp_pkg::ST_FINISH;
                else n_state = pacp_pkg::ST_IDLE;
            pacp_pkg::ST_FINISH:
                if (r_ovf) n_state = pacp_pkg::ST_OUTPUT;
                else n_state = pacp_pkg::ST_MUL_A;
            pacp_pkg::ST_DIV_X:
                if (cross_s == 0) n_state = pacp_pkg::ST_OUTPUT;
                else if (r_dstep == '0) n_state = pacp_pkg::ST_DIV_Y;
            pacp_pkg::ST_DIV_Y:
                if (r_dstep == '0) n_state = pacp_pkg::ST_OUTPUT;
            pacp_pkg::ST_OUTPUT:
                if (out_free) n_state = pacp_pkg::ST_IDLE;
            default: n_state = pacp_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= pacp_pkg::ST_IDLE;
        else r_state <= n_state;
    end

    // result word
    always_comb begin
        n_out = '0;
        if (r_ovf) begin
            n_out[100:99] = pacp_pkg::StatusOverflow;
        end else begin
            n_out[33:0] = (area_abs > 64'h3_FFFF_FFFF) ? '1 : area_abs[33:0];
            n_out[66:34] = r_len_sum[35:33] != 3'd0 ? '1 : r_len_sum[32:0];
            if (cross_s == 0) begin
                n_out[100:99] = pacp_pkg::StatusDegenerate;
            end else begin
                n_out[82:67] = r_cx;
                n_out[98:83] = r_cy;
                n_out[100:99] = pacp_pkg::StatusOk;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_out <= '0;
        end else if (r_state == pacp_pkg::ST_OUTPUT && out_free) begin
            r_out_valid <= 1'b1;
            r_out <= n_out;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_x <= '0; r_first_y <= '0; r_prev_x <= '0; r_prev_y <= '0;
            r_cur_x <= '0; r_cur_y <= '0;
            r_cross_sum <= '0; r_mom_x <= '0; r_mom_y <= '0; r_len_sum <= '0;
            r_count <= '0; r_ovf <= 1'b0; r_last <= 1'b0; r_closing <= 1'b0;
            r_c <= '0; r_sq <= '0; r_rem <= '0; r_root <= '0;
            r_dnum <= '0; r_drem <= '0; r_dden <= '0; r_dneg <= 1'b0;
            r_cx <= '0; r_cy <= '0;
            r_rstep <= '0; r_dstep <= '0;
        end else begin
            case (r_state)
                pacp_pkg::ST_IDLE:
                    if (s_axis_tvalid) begin
                        r_last <= s_axis_tlast;
                        r_closing <= 1'b0;
                        r_cur_x <= in_x;
                        r_cur_y <= in_y;
                        if (r_count == '0) begin
                            r_first_x <= in_x; r_first_y <= in_y;
                            r_prev_x <= in_x; r_prev_y <= in_y;
                            r_count <= pacp_pkg::CountBits'(1);
                        end else if (!do_edge_in) begin
                            r_ovf <= 1'b1;
                        end
                    end
                pacp_pkg::ST_MUL_A: r_c <= 33'(mul_p);
                pacp_pkg::ST_MUL_B: begin
                    r_c <= 33'(r_c - mul_p);
                    r_cross_sum <= r_cross_sum + 48'(r_c - mul_p);
                end
                pacp_pkg::ST_MOMENT_X: r_mom_x <= r_mom_x + 64'(mul_p);
                pacp_pkg::ST_MOMENT_Y: r_mom_y <= r_mom_y + 64'(mul_p);
                pacp_pkg::ST_SQ_DX: r_sq <= 64'(mul_p);
                pacp_pkg::ST_SQ_DY: begin
                    r_sq <= r_sq + 64'(mul_p);
                    r_rem <= '0; r_root <= '0;
                    r_rstep <= pacp_pkg::RootStepBits'(pacp_pkg::RootSteps - 1);
                end
                pacp_pkg::ST_ROOT: begin
                    r_rstep <= r_rstep - 1'b1;
                    if (rt_rem >= rt_trial) begin
                        r_rem <= rt_rem - rt_trial;
                        r_root <= rt_root_sh | 64'd1;
                    end else begin
                        r_rem <= rt_rem;
                        r_root <= rt_root_sh;
                    end
                end
                pacp_pkg::ST_EDGE_DONE: begin
                    if ({28'd0, r_len_sum} + r_root > 64'hF_FFFF_FFFF)
                        r_len_sum <= '1;
                    else
                        r_len_sum <= 36'(r_len_sum + r_root);
                    if (!r_closing) begin
                        r_prev_x <= r_cur_x; r_prev_y <= r_cur_y;
                        r_count <= r_count + 1'b1;
                    end else begin
                        r_dnum <= abs64(r_mom_x);
                        r_dneg <= r_mom_x[63] ^ den3[63];
                    end
                    r_drem <= '0;
                    r_dstep <= pacp_pkg::DivStepBits'(pacp_pkg::DivSteps - 1);
                    r_dden <= abs64(den3);
                end
                pacp_pkg::ST_FINISH: r_closing <= 1'b1;
                pacp_pkg::ST_DIV_X: begin
                    if (r_dstep == '0) begin
                        r_cx <= q_sat;
                        r_dnum <= abs64(r_mom_y);
                        r_dneg <= r_mom_y[63] ^ den3[63];
                        r_drem <= '0;
                        r_dstep <= pacp_pkg::DivStepBits'(pacp_pkg::DivSteps - 1);
                    end else begin
                        r_dstep <= r_dstep - 1'b1;
                        r_drem <= dv_ge ? 64'(dv_rem - {1'b0, r_dden}) : dv_rem[63:0];
                        r_dnum <= {r_dnum[62:0], dv_ge};
                    end
                end
                pacp_pkg::ST_DIV_Y: begin
                    r_dstep <= r_dstep - 1'b1;
                    r_drem <= dv_ge ? 64'(dv_rem - {1'b0, r_dden}) : dv_rem[63:0];
                    r_dnum <= {r_dnum[62:0], dv_ge};
                    if (r_dstep == '0) r_cy <= q_sat;
                end
                pacp_pkg::ST_OUTPUT:
                    if (out_free) begin
                        r_first_x <= '0; r_first_y <= '0; r_prev_x <= '0; r_prev_y <= '0;
                        r_cross_sum <= '0; r_mom_x <= '0; r_mom_y <= '0; r_len_sum <= '0;
                        r_count <= '0; r_ovf <= 1'b0; r_closing <= 1'b0;
                    end
                default: ;
            endcase
        end
    end

    // result register holds while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");
    // no input taken during the square root
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == pacp_pkg::ST_ROOT |-> !s_axis_tready)
        else $error("ready during root");
    // status code never reserved value
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[100:99] != 2'd3)
        else $error("bad status");

endmodule
